// ===== hw/rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// shared types, token codes and operator priorities for the postfix converter
// ----------------------------------------------------------------------------
package itp_pkg;

   localparam int unsigned ITP_STACK_DEPTH = 16;
   localparam int unsigned OP_W            = 5;
   localparam int unsigned VAL_W           = 32;

   typedef logic [1:0]              func_type;
   typedef logic [1:0]              kind_type;
   typedef logic [1:0]              err_type;
   typedef logic [OP_W-1:0]         op_type;
   typedef logic signed [VAL_W-1:0] value_type;
   typedef logic signed [4:0]       prio_type;

   // token kinds on the request side
   localparam func_type FUNC_OPERAND  = 2'd0;
   localparam func_type FUNC_OPERATOR = 2'd1;
   localparam func_type FUNC_EOL      = 2'd2;

   // result kinds
   localparam kind_type KIND_OPERAND  = 2'd0;
   localparam kind_type KIND_OPERATOR = 2'd1;
   localparam kind_type KIND_LINE_END = 2'd2;
   localparam kind_type KIND_ERROR    = 2'd3;

   // error codes
   localparam err_type ERR_NONE      = 2'd0;
   localparam err_type ERR_UNMATCHED = 2'd1;
   localparam err_type ERR_OVERFLOW  = 2'd2;

   // operator numbers
   localparam op_type OP_DEREF  = 5'd0;
   localparam op_type OP_THEN   = 5'd2;
   localparam op_type OP_ENDIF  = 5'd4;
   localparam op_type OP_ASSIGN = 5'd8;
   localparam op_type OP_LPAR   = 5'd10;
   localparam op_type OP_RPAR   = 5'd11;
   localparam op_type OP_LSQ    = 5'd12;
   localparam op_type OP_RSQ    = 5'd13;
   localparam op_type OP_LOR    = 5'd14;
   localparam op_type OP_LAND   = 5'd15;
   localparam op_type OP_BOR    = 5'd16;
   localparam op_type OP_BXOR   = 5'd17;
   localparam op_type OP_BAND   = 5'd18;
   localparam op_type OP_EQ     = 5'd19;
   localparam op_type OP_NE     = 5'd20;
   localparam op_type OP_SHL    = 5'd21;
   localparam op_type OP_SHR    = 5'd22;
   localparam op_type OP_LE     = 5'd23;
   localparam op_type OP_LT     = 5'd24;
   localparam op_type OP_GE     = 5'd25;
   localparam op_type OP_GT     = 5'd26;
   localparam op_type OP_ADD    = 5'd27;
   localparam op_type OP_SUB    = 5'd28;
   localparam op_type OP_MUL    = 5'd29;
   localparam op_type OP_DIV    = 5'd30;
   localparam op_type OP_MOD    = 5'd31;

   typedef struct packed {
      kind_type  kind;
      op_type    op_code;
      logic      tag;
      value_type value;
      err_type   err;
   } result_type;

   function automatic prio_type op_prio(input op_type op);
      prio_type p;
      case (op)
         OP_ASSIGN:                       p = 5'sd0;
         OP_LOR:                          p = 5'sd1;
         OP_LAND:                         p = 5'sd2;
         OP_BOR:                          p = 5'sd3;
         OP_BXOR:                         p = 5'sd4;
         OP_BAND:                         p = 5'sd5;
         OP_EQ, OP_NE:                    p = 5'sd6;
         OP_SHL, OP_SHR, OP_LE, OP_LT:    p = 5'sd7;
         OP_GE, OP_GT:                    p = 5'sd8;
         OP_ADD, OP_SUB:                  p = 5'sd9;
         OP_MUL, OP_DIV, OP_MOD:          p = 5'sd10;
         default:                         p = -5'sd1;
      endcase
      return p;
   endfunction

   function automatic logic is_opener(input op_type op);
      return (op == OP_LPAR) || (op == OP_LSQ);
   endfunction

endpackage

// ===== hw/rtl/itp_req_if.sv =====
// ----------------------------------------------------------------------------
// itp_req_if
// token channel into the converter, one item per valid/ready handshake
// ----------------------------------------------------------------------------
interface itp_req_if;
   logic                  valid;
   logic                  ready;
   itp_pkg::func_type     func;
   itp_pkg::op_type       op_code;
   logic                  operand_tag;
   itp_pkg::value_type    operand_value;

   modport source (output valid, func, op_code, operand_tag, operand_value,
                   input ready);
   modport sink   (input valid, func, op_code, operand_tag, operand_value,
                   output ready);
endinterface

// ===== hw/rtl/itp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// itp_rsp_if
// postfix result channel out of the converter
// ----------------------------------------------------------------------------
interface itp_rsp_if;
   logic                  valid;
   logic                  ready;
   itp_pkg::kind_type     out_kind;
   itp_pkg::op_type       out_op_code;
   logic                  out_operand_tag;
   itp_pkg::value_type    out_operand_value;
   itp_pkg::err_type      error_code;
   logic                  last;

   modport source (output valid, out_kind, out_op_code, out_operand_tag,
                   out_operand_value, error_code, last, input ready);
   modport sink   (input valid, out_kind, out_op_code, out_operand_tag,
                   out_operand_value, error_code, last, output ready);
endinterface

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// shunting-yard reordering of one line of tokens into postfix results
// ----------------------------------------------------------------------------
// an operand result is placed in the held result register in the work state
// and passed to the output register in the final state; the work state compares
// and pops one stack entry per cycle while no held result waits on a stalled
// output, and a new item is taken only once the block is back in idle
// reset: synchronous, clears the sequencer, stack count and output valid;
// stack storage is not cleared
module infix_to_postfix_converter #(
   parameter int unsigned STACK_DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   itp_req_if.sink    req,
   itp_rsp_if.source  rsp
);
   import itp_pkg::*;

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WORK,
      ST_FIN
   } state_type;

   state_type  state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   func_type   func_ff, func_in;
   op_type     op_ff, op_in;
   logic       tag_ff, tag_in;
   value_type  val_ff, val_in;
   logic       pend_valid_ff, pend_valid_in;
   result_type pend_ff, pend_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_ff, out_in;
   logic       out_last_ff, out_last_in;

   logic          stack_we;
   logic [AW-1:0] stack_waddr;
   logic [AW-1:0] stack_raddr;
   op_type        top;

   logic          can_emit;
   logic          have;
   op_type        want;
   logic          push;
   result_type    new_res;

   itp_stack #(
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (stack_we),
      .wr_addr (stack_waddr),
      .wr_data (op_ff),
      .rd_addr (stack_raddr),
      .rd_data (top)
   );

   assign can_emit    = !out_valid_ff || rsp.ready;
   assign have        = (cnt_ff != '0);
   assign want        = (op_ff == OP_RPAR) ? OP_LPAR : OP_LSQ;
   assign stack_waddr = cnt_ff[AW-1:0];
   assign stack_raddr = (cnt_in == '0) ? '0 : AW'(cnt_in - CW'(1));

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      func_in       = func_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      val_in        = val_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      out_last_in   = out_last_ff;
      stack_we      = 1'b0;
      push          = 1'b0;
      new_res       = '0;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               func_in  = req.func;
               op_in    = req.op_code;
               tag_in   = req.operand_tag;
               val_in   = req.operand_value;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            if (!pend_valid_ff || can_emit) begin
               case (func_ff)
                  FUNC_OPERAND: begin
                     push          = 1'b1;
                     new_res.kind  = KIND_OPERAND;
                     new_res.tag   = tag_ff;
                     new_res.value = val_ff;
                     state_in      = ST_FIN;
                  end
                  FUNC_EOL: begin
                     push = 1'b1;
                     if (have) begin
                        new_res.kind    = KIND_OPERATOR;
                        new_res.op_code = top;
                        cnt_in          = cnt_ff - CW'(1);
                     end else begin
                        new_res.kind = KIND_LINE_END;
                        state_in     = ST_FIN;
                     end
                  end
                  FUNC_OPERATOR: begin
                     if (op_ff == OP_THEN || op_ff == OP_ENDIF) begin
                        state_in = ST_FIN;
                     end else if (op_ff == OP_RPAR || op_ff == OP_RSQ) begin
                        if (have && !is_opener(top)) begin
                           push            = 1'b1;
                           new_res.kind    = KIND_OPERATOR;
                           new_res.op_code = top;
                           cnt_in          = cnt_ff - CW'(1);
                        end else if (have && top == want) begin
                           cnt_in   = cnt_ff - CW'(1);
                           state_in = ST_FIN;
                           if (op_ff == OP_RSQ) begin
                              push            = 1'b1;
                              new_res.kind    = KIND_OPERATOR;
                              new_res.op_code = OP_DEREF;
                           end
                        end else begin
                           push         = 1'b1;
                           new_res.kind = KIND_ERROR;
                           new_res.err  = ERR_UNMATCHED;
                           cnt_in       = '0;
                           state_in     = ST_FIN;
                        end
                     end else if (!is_opener(op_ff) && have && !is_opener(top)
                                  && op_prio(top) >= op_prio(op_ff)) begin
                        push            = 1'b1;
                        new_res.kind    = KIND_OPERATOR;
                        new_res.op_code = top;
                        cnt_in          = cnt_ff - CW'(1);
                     end else if (cnt_ff == CW'(STACK_DEPTH)) begin
                        push         = 1'b1;
                        new_res.kind = KIND_ERROR;
                        new_res.err  = ERR_OVERFLOW;
                        cnt_in       = '0;
                        state_in     = ST_FIN;
                     end else begin
                        stack_we = 1'b1;
                        cnt_in   = cnt_ff + CW'(1);
                        state_in = ST_FIN;
                     end
                  end
                  default: begin
                     state_in = ST_FIN;
                  end
               endcase
            end
         end
         ST_FIN: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (can_emit) begin
               out_valid_in  = 1'b1;
               out_in        = pend_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (push) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = pend_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_in       = new_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      func_ff     <= func_in;
      op_ff       <= op_in;
      tag_ff      <= tag_in;
      val_ff      <= val_in;
      pend_ff     <= pend_in;
      out_ff      <= out_in;
      out_last_ff <= out_last_in;
   end

   assign req.ready             = (state_ff == ST_IDLE);
   assign rsp.valid             = out_valid_ff;
   assign rsp.out_kind          = out_ff.kind;
   assign rsp.out_op_code       = out_ff.op_code;
   assign rsp.out_operand_tag   = out_ff.tag;
   assign rsp.out_operand_value = out_ff.value;
   assign rsp.error_code        = out_ff.err;
   assign rsp.last              = out_last_ff;

   // no held result may survive into the next item
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_valid_ff)
      else $error("held result left over when taking a new item");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      stack_we |-> cnt_ff < CW'(STACK_DEPTH))
      else $error("stack write while full");

   // an error always closes its item and carries a code
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.kind == KIND_ERROR |-> out_last_ff && out_ff.err != ERR_NONE)
      else $error("error result not final or without code");

endmodule

// ===== hw/rtl/itp_stack.sv =====
// ----------------------------------------------------------------------------
// itp_stack
// operator stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module itp_stack #(
   parameter int unsigned DEPTH = itp_pkg::ITP_STACK_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  itp_pkg::op_type          wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output itp_pkg::op_type          rd_data
);
   import itp_pkg::*;

   op_type mem [DEPTH];
   op_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
